// ----- rtl/core/tsm_pkg.sv -----
package tsm_pkg;

    typedef struct packed {
        logic insert;
        logic rotate;
    } tsm_ctl_t;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 7;
    localparam int LEN_CFG_W   = 7;
    localparam int TRIM_W      = 5;
    localparam int AVG_W       = 16;

    localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_LEN = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_TRIM_COUNT = 2'd1;

    localparam logic [LEN_CFG_W-1:0] WINDOW_LEN_RST = 7'd64;
    localparam logic [TRIM_W-1:0]    TRIM_COUNT_RST = 5'd1;

endpackage

// ----- rtl/core/tsm_cell.sv -----
module tsm_cell #(
    parameter int VAL_W    = 16,
    parameter int AGE_W    = 6,
    parameter int AGE_LAST = 63
) (
    input  logic               clk,
    input  logic               rst_n,
    input  tsm_pkg::tsm_ctl_t  ctl,
    input  logic [VAL_W-1:0]   new_val,
    input  logic [VAL_W-1:0]   left_val,
    input  logic [AGE_W-1:0]   left_age,
    input  logic               left_valid,
    input  logic               left_gt,
    input  logic [VAL_W-1:0]   right_val,
    input  logic [AGE_W-1:0]   right_age,
    input  logic               right_valid,
    input  logic               right_gt,
    input  logic               at_del,
    input  logic               after_del,
    output logic [VAL_W-1:0]   cell_val,
    output logic [AGE_W-1:0]   cell_age,
    output logic               cell_valid,
    output logic               gt,
    output logic               del_hit
);

    logic [VAL_W-1:0] val_reg;
    logic [VAL_W-1:0] val_next;
    logic [AGE_W-1:0] age_reg;
    logic [AGE_W-1:0] age_next;
    logic             valid_reg;
    logic             valid_next;

    assign gt         = !valid_reg || (val_reg > new_val);
    assign del_hit    = valid_reg && (age_reg == AGE_W'(AGE_LAST));
    assign cell_val   = val_reg;
    assign cell_age   = age_reg;
    assign cell_valid = valid_reg;

    // rotation toward the head, or sorted insert of new_val with removal of the oldest entry in one step
    always_comb
    begin
        val_next   = val_reg;
        age_next   = age_reg;
        valid_next = valid_reg;
        if (ctl.rotate)
        begin
            val_next   = right_val;
            age_next   = right_age;
            valid_next = right_valid;
        end
        else if (ctl.insert)
        begin
            if (after_del)
            begin
                if (!right_gt)
                begin
                    val_next   = right_val;
                    age_next   = right_age + AGE_W'(1);
                    valid_next = right_valid;
                end
                else if (!gt)
                begin
                    val_next   = new_val;
                    age_next   = '0;
                    valid_next = 1'b1;
                end
                else
                begin
                    age_next = age_reg + AGE_W'(1);
                end
            end
            else if (at_del)
            begin
                if (!right_gt)
                begin
                    val_next   = right_val;
                    age_next   = right_age + AGE_W'(1);
                    valid_next = right_valid;
                end
                else if (!left_gt)
                begin
                    val_next   = new_val;
                    age_next   = '0;
                    valid_next = 1'b1;
                end
                else
                begin
                    val_next   = left_val;
                    age_next   = left_age + AGE_W'(1);
                    valid_next = left_valid;
                end
            end
            else
            begin
                if (!gt)
                begin
                    age_next = age_reg + AGE_W'(1);
                end
                else if (!left_gt)
                begin
                    val_next   = new_val;
                    age_next   = '0;
                    valid_next = 1'b1;
                end
                else
                begin
                    val_next   = left_val;
                    age_next   = left_age + AGE_W'(1);
                    valid_next = left_valid;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
        age_reg <= age_next;
    end

endmodule

// ----- rtl/core/tsm_chain.sv -----
module tsm_chain #(
    parameter int DEPTH = 64,
    parameter int VAL_W = 16,
    parameter int IDX_W = 6
) (
    input  logic               clk,
    input  logic               rst_n,
    input  tsm_pkg::tsm_ctl_t  ctl,
    input  logic [VAL_W-1:0]   new_val,
    output logic [VAL_W-1:0]   head_val,
    output logic [IDX_W-1:0]   head_age,
    output logic               head_valid
);

    logic [VAL_W-1:0] val_a   [DEPTH];
    logic [IDX_W-1:0] age_a   [DEPTH];
    logic [DEPTH-1:0] valid_v;
    logic [DEPTH-1:0] gt_v;
    logic [DEPTH-1:0] hit_v;
    logic [IDX_W-1:0] del_idx;
    logic             del_any;

    always_comb
    begin
        del_idx = '0;
        for (int k = 0; k < DEPTH; k++)
        begin
            if (hit_v[k])
            begin
                del_idx = del_idx | IDX_W'(k);
            end
        end
    end

    assign del_any = |hit_v;

    for (genvar k = 0; k < DEPTH; k++)
    begin : g_cell
        logic [VAL_W-1:0] l_val;
        logic [IDX_W-1:0] l_age;
        logic             l_valid;
        logic             l_gt;
        logic [VAL_W-1:0] r_val;
        logic [IDX_W-1:0] r_age;
        logic             r_valid;
        logic             r_gt;
        logic             after_del;

        if (k == 0)
        begin : g_first
            assign l_val   = new_val;
            assign l_age   = '0;
            assign l_valid = 1'b0;
            assign l_gt    = 1'b0;
        end
        else
        begin : g_mid
            assign l_val   = val_a[k-1];
            assign l_age   = age_a[k-1];
            assign l_valid = valid_v[k-1];
            assign l_gt    = gt_v[k-1];
        end

        // the last cell wraps to the head for rotation; past the end reads as empty
        if (k == DEPTH - 1)
        begin : g_last
            assign r_val   = val_a[0];
            assign r_age   = age_a[0];
            assign r_valid = valid_v[0];
            assign r_gt    = 1'b1;
        end
        else
        begin : g_inner
            assign r_val   = val_a[k+1];
            assign r_age   = age_a[k+1];
            assign r_valid = valid_v[k+1];
            assign r_gt    = gt_v[k+1];
        end

        assign after_del = del_any && (IDX_W'(k) > del_idx);

        tsm_cell #(
            .VAL_W    (VAL_W),
            .AGE_W    (IDX_W),
            .AGE_LAST (DEPTH - 1)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctl         (ctl),
            .new_val     (new_val),
            .left_val    (l_val),
            .left_age    (l_age),
            .left_valid  (l_valid),
            .left_gt     (l_gt),
            .right_val   (r_val),
            .right_age   (r_age),
            .right_valid (r_valid),
            .right_gt    (r_gt),
            .at_del      (hit_v[k]),
            .after_del   (after_del),
            .cell_val    (val_a[k]),
            .cell_age    (age_a[k]),
            .cell_valid  (valid_v[k]),
            .gt          (gt_v[k]),
            .del_hit     (hit_v[k])
        );
    end

    assign head_val   = val_a[0];
    assign head_age   = age_a[0];
    assign head_valid = valid_v[0];

    a_single_evict: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(hit_v))
        else $error("more than one cell holds the oldest age");

    a_evict_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        del_any |-> (&valid_v))
        else $error("eviction while chain not full");

endmodule

// ----- rtl/core/tsm_div.sv -----
module tsm_div #(
    parameter int DVD_W = 22,
    parameter int DVS_W = 7
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic             done,
    output logic [DVD_W-1:0] quotient
);

    localparam int STEP_W = $clog2(DVD_W + 1);

    logic              busy_reg;
    logic              busy_next;
    logic              done_reg;
    logic              done_next;
    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    logic [DVS_W-1:0]  rem_reg;
    logic [DVS_W-1:0]  rem_next;
    logic [DVD_W-1:0]  dq_reg;
    logic [DVD_W-1:0]  dq_next;
    logic [DVS_W:0]    shifted;
    logic [DVS_W:0]    diff;
    logic              ge;

    // restoring division, one quotient bit per cycle
    assign shifted = {rem_reg, dq_reg[DVD_W-1]};
    assign diff    = shifted - {1'b0, divisor};
    assign ge      = shifted >= {1'b0, divisor};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rem_next  = rem_reg;
        dq_next   = dq_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = '0;
            rem_next  = '0;
            dq_next   = dividend;
        end
        else if (busy_reg)
        begin
            rem_next  = ge ? diff[DVS_W-1:0] : shifted[DVS_W-1:0];
            dq_next   = {dq_reg[DVD_W-2:0], ge};
            step_next = step_reg + STEP_W'(1);
            if (step_reg == STEP_W'(DVD_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dq_reg  <= dq_next;
    end

    assign done     = done_reg;
    assign quotient = dq_reg;

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy_reg) && !busy_reg)
        else $error("divider done without a finished run");

endmodule

// ----- rtl/core/sliding_window_trimmed_mean_core.sv -----
// Sliding-window trimmed mean.
// sample channel (sample_valid/sample_ready/sample): one unsigned sample per item.
// result channel (result_valid/result_ready/average/ready_res): one result per
// sample; ready_res is 0 and average 0 until window_len samples have arrived,
// when window_len is 0 or when 2*trim_count >= window_len.
// cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data): index 0 window_len,
// index 1 trim_count; always ready, write only while no item is in flight.
// Samples are held in a sorted row of WINDOW_MAX cells tagged with age. An
// accepted sample is inserted (and, once the row is full, the oldest evicted)
// in the accept cycle, then the row rotates once around while the head cell
// feeds the rank counter and the middle sum, then a bit-serial divider forms
// the quotient, which is passed in S_OUT to the result register once that
// register is free. A not-ready result goes from the accept straight to S_OUT.
// One item is processed at a time: a new sample is taken only in S_IDLE, after
// the previous result has gone to the result register.
// Reset empties the row, clears the fill count and loads window_len=64,
// trim_count=1. A stalled receiver holds the result register; the next sample
// is still taken and worked, and its result waits until the register frees.
module sliding_window_trimmed_mean_core #(
    parameter int WINDOW_MAX  = 64,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              sample_valid,
    output logic                              sample_ready,
    input  logic [SAMPLE_BITS-1:0]            sample,
    output logic                              result_valid,
    input  logic                              result_ready,
    output logic [tsm_pkg::AVG_W-1:0]         average,
    output logic                              ready_res,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [tsm_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [tsm_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int IDX_W = $clog2(WINDOW_MAX);
    localparam int CNT_W = $clog2(WINDOW_MAX + 1);
    localparam int LEN_W = (CNT_W > tsm_pkg::LEN_CFG_W) ? CNT_W : tsm_pkg::LEN_CFG_W;
    localparam int SUM_W = SAMPLE_BITS + CNT_W;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_DIV  = 2'd2;
    localparam logic [1:0] S_OUT  = 2'd3;

    logic [1:0]                       state_reg;
    logic [1:0]                       state_next;
    logic [tsm_pkg::LEN_CFG_W-1:0]    window_len_reg;
    logic [tsm_pkg::TRIM_W-1:0]       trim_reg;
    logic [CNT_W-1:0]                 fill_reg;
    logic [CNT_W-1:0]                 fill_next;
    logic [CNT_W-1:0]                 fill_sat;
    logic                             rdy_flag_reg;
    logic                             rdy_flag_next;
    logic [IDX_W-1:0]                 scan_reg;
    logic [IDX_W-1:0]                 scan_next;
    logic [CNT_W-1:0]                 rank_reg;
    logic [CNT_W-1:0]                 rank_next;
    logic [SUM_W-1:0]                 sum_reg;
    logic [SUM_W-1:0]                 sum_next;
    logic                             result_valid_reg;
    logic                             result_valid_next;
    logic [tsm_pkg::AVG_W-1:0]        avg_reg;
    logic                             rdy_out_reg;

    logic [LEN_W-1:0]                 wl_raw;
    logic [LEN_W-1:0]                 wl;
    logic [LEN_W-1:0]                 trim_ext;
    logic [LEN_W-1:0]                 trim2;
    logic [LEN_W-1:0]                 hi;
    logic [LEN_W-1:0]                 divisor;
    logic                             accept;
    logic                             out_free;
    logic                             ready_cond;
    logic                             scan_last;
    logic                             in_win;
    logic                             take;
    logic                             div_start;
    logic                             div_done;
    logic [SUM_W-1:0]                 div_quot;

    tsm_pkg::tsm_ctl_t                ctl;
    logic [SAMPLE_BITS-1:0]           head_val;
    logic [IDX_W-1:0]                 head_age;
    logic                             head_valid;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_len_reg <= tsm_pkg::WINDOW_LEN_RST;
            trim_reg       <= tsm_pkg::TRIM_COUNT_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                tsm_pkg::REG_WINDOW_LEN: window_len_reg <= cfg_data;
                tsm_pkg::REG_TRIM_COUNT: trim_reg <= cfg_data[tsm_pkg::TRIM_W-1:0];
                default: ;
            endcase
        end
    end

    assign wl_raw   = LEN_W'(window_len_reg);
    assign wl       = (wl_raw > LEN_W'(WINDOW_MAX)) ? LEN_W'(WINDOW_MAX) : wl_raw;
    assign trim_ext = LEN_W'(trim_reg);
    assign trim2    = trim_ext << 1;
    assign hi       = wl - trim_ext;
    assign divisor  = wl - trim2;

    assign sample_ready = (state_reg == S_IDLE);
    assign accept       = sample_valid && sample_ready;
    assign out_free     = !result_valid_reg || result_ready;

    assign fill_sat   = (fill_reg == CNT_W'(WINDOW_MAX)) ? fill_reg : fill_reg + CNT_W'(1);
    assign ready_cond = (wl != '0) && (LEN_W'(fill_sat) >= wl) && (trim2 < wl);

    assign scan_last = (scan_reg == IDX_W'(WINDOW_MAX - 1));
    assign in_win    = head_valid && (LEN_W'(head_age) < wl);
    assign take      = in_win && (LEN_W'(rank_reg) >= trim_ext) && (LEN_W'(rank_reg) < hi);
    assign div_start = (state_reg == S_SCAN) && scan_last;

    assign ctl.insert = accept;
    assign ctl.rotate = (state_reg == S_SCAN);

    always_comb
    begin
        state_next        = state_reg;
        fill_next         = fill_reg;
        rdy_flag_next     = rdy_flag_reg;
        scan_next         = scan_reg;
        rank_next         = rank_reg;
        sum_next          = sum_reg;
        result_valid_next = result_valid_reg;
        if (result_valid_reg && result_ready)
        begin
            result_valid_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    fill_next     = fill_sat;
                    rdy_flag_next = ready_cond;
                    scan_next     = '0;
                    rank_next     = '0;
                    sum_next      = '0;
                    state_next    = ready_cond ? S_SCAN : S_OUT;
                end
            end
            S_SCAN:
            begin
                if (take)
                begin
                    sum_next = sum_reg + SUM_W'(head_val);
                end
                if (in_win)
                begin
                    rank_next = rank_reg + CNT_W'(1);
                end
                scan_next = scan_reg + IDX_W'(1);
                if (scan_last)
                begin
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    result_valid_next = 1'b1;
                    state_next        = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            fill_reg         <= '0;
            rdy_flag_reg     <= 1'b0;
            scan_reg         <= '0;
            rank_reg         <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            fill_reg         <= fill_next;
            rdy_flag_reg     <= rdy_flag_next;
            scan_reg         <= scan_next;
            rank_reg         <= rank_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sum_reg <= sum_next;
        if ((state_reg == S_OUT) && out_free)
        begin
            avg_reg     <= rdy_flag_reg ? tsm_pkg::AVG_W'(div_quot) : '0;
            rdy_out_reg <= rdy_flag_reg;
        end
    end

    assign result_valid = result_valid_reg;
    assign average      = avg_reg;
    assign ready_res    = rdy_out_reg;

    tsm_chain #(
        .DEPTH (WINDOW_MAX),
        .VAL_W (SAMPLE_BITS),
        .IDX_W (IDX_W)
    ) u_chain (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .new_val    (sample),
        .head_val   (head_val),
        .head_age   (head_age),
        .head_valid (head_valid)
    );

    tsm_div #(
        .DVD_W (SUM_W),
        .DVS_W (LEN_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_next),
        .divisor  (divisor),
        .done     (div_done),
        .quotient (div_quot)
    );

    a_not_ready_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !ready_res |-> average == '0)
        else $error("not-ready result carries a nonzero average");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CNT_W'(WINDOW_MAX))
        else $error("fill count beyond window depth");

endmodule

// ----- tb/sliding_window_trimmed_mean_core_tb.sv -----
module sliding_window_trimmed_mean_core_tb;

    localparam int WIN_MAX  = 64;
    localparam int SAMPLE_W = 16;
    localparam int ITEM_TARGET = 650;

    typedef struct packed {
        logic [tsm_pkg::AVG_W-1:0] average;
        logic                      ready_res;
    } mean_result_t;

    class trimmed_mean_scoreboard;
        logic [tsm_pkg::LEN_CFG_W-1:0] window_len = tsm_pkg::WINDOW_LEN_RST;
        logic [tsm_pkg::TRIM_W-1:0]    trim_count = tsm_pkg::TRIM_COUNT_RST;
        logic [SAMPLE_W-1:0]  history [WIN_MAX];
        int unsigned          fill_count = 0;
        int unsigned          write_slot = 0;
        mean_result_t         pending_means [$];
        int                   errors = 0;

        function void configure(logic [tsm_pkg::LEN_CFG_W-1:0] wl,
                                logic [tsm_pkg::TRIM_W-1:0] tc);
            window_len = wl;
            trim_count = tc;
        endfunction

        // predicts the trimmed mean that this sample produces
        function void note_sample(logic [SAMPLE_W-1:0] s);
            logic [SAMPLE_W-1:0] win [WIN_MAX];
            logic [SAMPLE_W-1:0] v;
            int unsigned wl;
            int unsigned i;
            int unsigned j;
            int unsigned total;
            int unsigned divisor;
            mean_result_t r;
            history[write_slot] = s;
            write_slot = (write_slot + 1) % WIN_MAX;
            if (fill_count < WIN_MAX)
            begin
                fill_count++;
            end
            wl = (window_len > WIN_MAX) ? WIN_MAX : window_len;
            r = '0;
            if (wl > 0 && fill_count >= wl && 2 * trim_count < wl)
            begin
                for (i = 0; i < wl; i++)
                begin
                    v = history[(write_slot + WIN_MAX - 1 - i) % WIN_MAX];
                    j = i;
                    while (j > 0 && win[j-1] > v)
                    begin
                        win[j] = win[j-1];
                        j--;
                    end
                    win[j] = v;
                end
                total = 0;
                for (i = trim_count; i < wl - trim_count; i++)
                begin
                    total += win[i];
                end
                divisor = wl - 2 * trim_count;
                r.average   = tsm_pkg::AVG_W'(total / divisor);
                r.ready_res = 1'b1;
            end
            pending_means.push_back(r);
        endfunction

        function void check_result(logic [tsm_pkg::AVG_W-1:0] avg, logic rdy);
            mean_result_t e;
            if (pending_means.size() == 0)
            begin
                $error("unexpected result: average %0d ready_res %0d", avg, rdy);
                errors++;
            end
            else
            begin
                e = pending_means.pop_front();
                if (avg !== e.average)
                begin
                    $error("average: expected %0d, actual %0d", e.average, avg);
                    errors++;
                end
                if (rdy !== e.ready_res)
                begin
                    $error("ready_res: expected %0d, actual %0d", e.ready_res, rdy);
                    errors++;
                end
            end
        endfunction
    endclass

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            sample_valid = 1'b0;
    logic                            sample_ready;
    logic [SAMPLE_W-1:0]             sample = '0;
    logic                            result_valid;
    logic                            result_ready = 1'b0;
    logic [tsm_pkg::AVG_W-1:0]       average;
    logic                            ready_res;
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [tsm_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [tsm_pkg::CFG_DATA_W-1:0]  cfg_data = '0;

    trimmed_mean_scoreboard sb;
    bit                     sender_calm = 1'b0;
    bit                     receiver_calm = 1'b0;
    int                     items_sent = 0;
    logic [SAMPLE_W-1:0]    last_sample = '0;

    sliding_window_trimmed_mean_core #(
        .WINDOW_MAX  (WIN_MAX),
        .SAMPLE_BITS (SAMPLE_W)
    ) DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample       (sample),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .average      (average),
        .ready_res    (ready_res),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #5 clk = ~clk;

    task automatic send_sample(logic [SAMPLE_W-1:0] v);
        int gap;
        gap = sender_calm ? 0 : $urandom_range(0, 16);
        if (gap > 0)
        begin
            sample_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sample_valid <= 1'b1;
        sample       <= v;
        do @(posedge clk); while (sample_ready !== 1'b1);
        sb.note_sample(v);
        last_sample = v;
        items_sent++;
    endtask

    task automatic wait_drained();
        while (sb.pending_means.size() != 0) @(posedge clk);
    endtask

    task automatic write_config(logic [tsm_pkg::LEN_CFG_W-1:0] wl,
                                logic [tsm_pkg::TRIM_W-1:0] tc);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_index <= tsm_pkg::REG_WINDOW_LEN;
        cfg_data  <= tsm_pkg::CFG_DATA_W'(wl);
        do @(posedge clk); while (cfg_ready !== 1'b1);
        cfg_index <= tsm_pkg::REG_TRIM_COUNT;
        cfg_data  <= tsm_pkg::CFG_DATA_W'(tc);
        do @(posedge clk); while (cfg_ready !== 1'b1);
        cfg_valid <= 1'b0;
        sb.configure(wl, tc);
    endtask

    function automatic logic [SAMPLE_W-1:0] next_sample();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2: return SAMPLE_W'($urandom_range(0, 15));
            3: return last_sample;
            4: return SAMPLE_W'($urandom_range(16'hFFF0, 16'hFFFF));
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    // receiver side
    initial
    begin
        int stall;
        forever
        begin
            stall = receiver_calm ? 0 : $urandom_range(0, 16);
            if (stall > 0)
            begin
                result_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            result_ready <= 1'b1;
            do @(posedge clk); while (result_valid !== 1'b1);
            sb.check_result(average, ready_res);
        end
    end

    initial
    begin
        #5_000_000;
        $display("FAIL sliding_window_trimmed_mean_core");
        $finish;
    end

    initial
    begin
        int phase;
        int n;
        int lo;
        logic [tsm_pkg::LEN_CFG_W-1:0] wl;
        logic [tsm_pkg::TRIM_W-1:0]    tc;
        sb = new;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // window not yet full under reset settings
        send_sample('0);
        send_sample('1);
        send_sample(16'd1);
        sample_valid <= 1'b0;

        write_config(7'd3, 5'd1);
        send_sample('1);
        send_sample('0);
        send_sample('1);
        send_sample(16'h8000);
        send_sample('0);
        sample_valid <= 1'b0;

        // trim too large
        write_config(7'd4, 5'd2);
        send_sample(16'h5555);
        send_sample(16'hAAAA);
        sample_valid <= 1'b0;

        // zero window length
        write_config(7'd0, 5'd0);
        send_sample('1);
        send_sample(16'h1234);
        sample_valid <= 1'b0;

        // above the maximum window: saturates, still filling
        write_config(7'd127, 5'd0);
        send_sample(16'h7FFF);
        send_sample('1);
        sample_valid <= 1'b0;

        // no trimming: plain mean
        write_config(7'd5, 5'd0);
        send_sample('1);
        send_sample(16'd2);
        send_sample(16'd3);
        sample_valid <= 1'b0;

        write_config(7'd64, 5'd31);
        send_sample('1);
        send_sample('0);
        send_sample(16'hFFFE);
        sample_valid <= 1'b0;

        phase = 0;
        while (items_sent < ITEM_TARGET)
        begin
            case (phase)
                0: begin wl = 7'd64;  tc = 5'd31; end
                1: begin wl = 7'd64;  tc = 5'd0;  end
                2: begin wl = 7'd127; tc = 5'd31; end
                3: begin wl = 7'd3;   tc = 5'd1;  end
                default:
                begin
                    case ($urandom_range(0, 9))
                        0:
                        begin
                            wl = tsm_pkg::LEN_CFG_W'($urandom_range(0, 2));
                            tc = tsm_pkg::TRIM_W'($urandom_range(0, 31));
                        end
                        1:
                        begin
                            wl = tsm_pkg::LEN_CFG_W'($urandom_range(65, 127));
                            tc = tsm_pkg::TRIM_W'($urandom_range(0, 31));
                        end
                        2:
                        begin
                            wl = tsm_pkg::LEN_CFG_W'($urandom_range(3, 64));
                            lo = (wl + 1) / 2;
                            if (lo > 31)
                            begin
                                lo = 31;
                            end
                            tc = tsm_pkg::TRIM_W'($urandom_range(lo, 31));
                        end
                        default:
                        begin
                            wl = tsm_pkg::LEN_CFG_W'($urandom_range(3, 64));
                            lo = (wl - 1) / 2;
                            if (lo > 31)
                            begin
                                lo = 31;
                            end
                            tc = tsm_pkg::TRIM_W'($urandom_range(0, lo));
                        end
                    endcase
                end
            endcase
            write_config(wl, tc);
            sender_calm   = ($urandom_range(0, 3) == 0);
            receiver_calm = ($urandom_range(0, 3) == 0);
            n = $urandom_range(15, 60);
            repeat (n) send_sample(next_sample());
            sample_valid <= 1'b0;
            phase++;
        end

        wait_drained();
        repeat (100) @(posedge clk);
        if (sb.errors == 0)
        begin
            $display("PASS sliding_window_trimmed_mean_core");
        end
        else
        begin
            $display("FAIL sliding_window_trimmed_mean_core");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/core/tsm_pkg.sv
rtl/core/tsm_cell.sv
rtl/core/tsm_chain.sv
rtl/core/tsm_div.sv
rtl/core/sliding_window_trimmed_mean_core.sv
tb/sliding_window_trimmed_mean_core_tb.sv
